// ===== rtl/core/ucle_pkg.sv =====
// shared types, constants and helpers for the utf-16 console line editor
package ucle_pkg;

  // default line capacity in code units
  localparam int unsigned LINE_CAPACITY_DEF = 256;

  // key codes that steer the editor
  localparam logic [7:0]  VK_ESC      = 8'h1B;
  localparam logic [7:0]  VK_RET      = 8'h0D;
  localparam logic [7:0]  VK_BKSP     = 8'h08;
  localparam logic [7:0]  VK_LETTER_C = 8'h43;
  localparam logic [15:0] U_ESC       = 16'h001B;
  localparam logic [15:0] U_RET       = 16'h000D;
  localparam logic [15:0] U_BKSP      = 16'h0008;
  localparam logic [15:0] U_DEL       = 16'h007F;
  localparam logic [15:0] U_CTRL_C    = 16'h0003;
  localparam logic [15:0] U_SPACE     = 16'h0020;
  localparam logic [15:0] HIGH_FIRST  = 16'hD800;
  localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST   = 16'hDC00;
  localparam logic [15:0] LOW_LAST    = 16'hDFFF;

  // operation carried on tuser
  typedef enum logic {
    OP_KEY  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // line status reported with each result
  typedef enum logic [2:0] {
    ST_OPEN     = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_ABORTED  = 3'd2,
    ST_INVALID  = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  // fields of one key event
  typedef struct packed {
    logic        is_key;
    logic        key_down;
    logic [7:0]  virtual_key;
    logic        ctrl_pressed;
    logic [15:0] unit;
    logic [15:0] repeat_req;
  } key_t;

  // one result transaction
  typedef struct packed {
    status_t     status;
    logic [8:0]  line_length;
    logic        surrogate_pending;
    logic [15:0] read_unit;
    logic        read_valid;
  } result_t;

  function automatic logic is_high_half(input logic [15:0] u);
    return (u >= HIGH_FIRST) && (u <= HIGH_LAST);
  endfunction

  function automatic logic is_low_half(input logic [15:0] u);
    return (u >= LOW_FIRST) && (u <= LOW_LAST);
  endfunction

endpackage

// ===== rtl/core/utf16_console_line_editor_unit.sv =====
// top level of the utf-16 console line editor with its output register
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_tvalid/in_tready   | tuser op, tdata key event and read index
//  out_    | output    | out_tvalid/out_tready | tdata status, length, read data
//
// a read passes through S_READ and S_RD_WAIT to S_DONE; a key event ends at S_CHECK
// or loops in S_EDIT, an append or a held or dropped high half there alone, a pair
// via S_PAIR2, a backspace via S_BK_WAIT (single write port, registered reads)
// reset clears the line length, the held surrogate and the closed flag, not the memory
// one item is in work at a time, the next is accepted in S_IDLE, which is entered as its result is
// registered; a result waiting in the output register blocks only the next completion
module utf16_console_line_editor_unit #(
  parameter int unsigned LINE_CAPACITY = ucle_pkg::LINE_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // is_key, key_down, virtual_key[7:0], ctrl_pressed,
                                  // unit[15:0], repeat_req[15:0], read_index[7:0], zero fill
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // status[2:0], line_length[8:0], surrogate_pending,
                                  // read_unit[15:0], read_valid, zero fill
);

  localparam int unsigned AW = $clog2(LINE_CAPACITY);
  localparam int unsigned CW = $clog2(LINE_CAPACITY + 1);

  ucle_pkg::key_t    in_key;
  ucle_pkg::op_t     in_op;
  logic [7:0]        in_index;
  logic              res_valid, res_ready;
  ucle_pkg::result_t res;
  ucle_pkg::result_t out_res_r;
  logic              out_valid_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr0, mem_raddr1;
  logic [15:0]       mem_wdata, mem_rdata0, mem_rdata1;

  // unpack the input transaction
  always_comb begin
    in_op              = ucle_pkg::op_t'(in_tuser);
    in_key.is_key       = in_tdata[0];
    in_key.key_down     = in_tdata[1];
    in_key.virtual_key  = in_tdata[9:2];
    in_key.ctrl_pressed = in_tdata[10];
    in_key.unit         = in_tdata[26:11];
    in_key.repeat_req   = in_tdata[42:27];
    in_index            = in_tdata[50:43];
  end

  ucle_ctrl #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .AW            (AW),
    .CW            (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_op    (in_op),
    .item_key   (in_key),
    .item_index (in_index),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr0 (mem_raddr0),
    .mem_raddr1 (mem_raddr1),
    .mem_rdata0 (mem_rdata0),
    .mem_rdata1 (mem_rdata1)
  );

  ucle_line_mem #(
    .DEPTH (LINE_CAPACITY),
    .AW    (AW)
  ) u_line_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (mem_raddr1),
    .rdata0 (mem_rdata0),
    .rdata1 (mem_rdata1)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // pack the output transaction
  always_comb begin
    out_tvalid       = out_valid_r;
    out_tdata[2:0]   = out_res_r.status;
    out_tdata[11:3]  = out_res_r.line_length;
    out_tdata[12]    = out_res_r.surrogate_pending;
    out_tdata[28:13] = out_res_r.read_unit;
    out_tdata[29]    = out_res_r.read_valid;
    out_tdata[31:30] = 2'b00;
  end

endmodule

// ===== rtl/core/ucle_line_mem.sv =====
// line buffer memory: one write port, two registered read ports
module ucle_line_mem #(
  parameter int unsigned DEPTH = ucle_pkg::LINE_CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [15:0]   rdata0,
  output logic [15:0]   rdata1
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== rtl/core/ucle_ctrl.sv =====
// sequencer: decodes key events, walks the repeats, edits the line memory and serves reads
module ucle_ctrl #(
  parameter int unsigned LINE_CAPACITY = ucle_pkg::LINE_CAPACITY_DEF,
  parameter int unsigned AW            = $clog2(LINE_CAPACITY),
  parameter int unsigned CW            = $clog2(LINE_CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // item side
  input  logic              item_valid,
  output logic              item_ready,
  input  ucle_pkg::op_t     item_op,
  input  ucle_pkg::key_t    item_key,
  input  logic [7:0]        item_index,
  // result side
  output logic              res_valid,
  input  logic              res_ready,
  output ucle_pkg::result_t res,
  // line memory
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [15:0]       mem_wdata,
  output logic [AW-1:0]     mem_raddr0,
  output logic [AW-1:0]     mem_raddr1,
  input  logic [15:0]       mem_rdata0,
  input  logic [15:0]       mem_rdata1
);

  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_EDIT    = 8'b0000_0100,
    S_BK_WAIT = 8'b0000_1000,
    S_PAIR2   = 8'b0001_0000,
    S_READ    = 8'b0010_0000,
    S_RD_WAIT = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  ucle_pkg::op_t      op_r, op_nxt;
  ucle_pkg::key_t     key_r, key_nxt;
  logic [7:0]         idx_r, idx_nxt;
  logic [15:0]        rep_r, rep_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [15:0]        held_r, held_nxt;
  logic               closed_r, closed_nxt;
  ucle_pkg::status_t  status_r, status_nxt;
  logic [15:0]        rd_unit_r, rd_unit_nxt;
  logic               rd_valid_r, rd_valid_nxt;

  logic is_esc, is_ctrl_c, is_ret, is_bksp, is_hi, is_lo, is_print, held_any;
  logic pair_no_room, line_full, rd_in_range;

  // event decode from the held item
  always_comb begin
    is_esc    = (key_r.virtual_key == ucle_pkg::VK_ESC) || (key_r.unit == ucle_pkg::U_ESC);
    is_ctrl_c = (key_r.unit == ucle_pkg::U_CTRL_C) ||
                ((key_r.virtual_key == ucle_pkg::VK_LETTER_C) && key_r.ctrl_pressed);
    is_ret    = (key_r.virtual_key == ucle_pkg::VK_RET) || (key_r.unit == ucle_pkg::U_RET);
    is_bksp   = (key_r.virtual_key == ucle_pkg::VK_BKSP) ||
                (key_r.unit == ucle_pkg::U_BKSP) || (key_r.unit == ucle_pkg::U_DEL);
    is_hi     = ucle_pkg::is_high_half(key_r.unit);
    is_lo     = ucle_pkg::is_low_half(key_r.unit);
    is_print  = key_r.unit >= ucle_pkg::U_SPACE;
    held_any  = held_r != 16'd0;
    pair_no_room = ((CW+1)'(count_r) + (CW+1)'(2)) > (CW+1)'(LINE_CAPACITY);
    line_full    = count_r >= CW'(LINE_CAPACITY);
    rd_in_range  = CMPW'(idx_r) < CMPW'(count_r);
  end

  // memory addressing: tail and the unit before it, or the read index
  always_comb begin
    mem_waddr  = AW'(count_r);
    mem_raddr0 = (state_r == S_READ) ? AW'(idx_r) : AW'(count_r - CW'(1));
    mem_raddr1 = AW'(count_r - CW'(2));
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    rep_nxt      = rep_r;
    count_nxt    = count_r;
    held_nxt     = held_r;
    closed_nxt   = closed_r;
    status_nxt   = status_r;
    rd_unit_nxt  = rd_unit_r;
    rd_valid_nxt = rd_valid_r;
    mem_we       = 1'b0;
    mem_wdata    = key_r.unit;

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          op_nxt  = item_op;
          key_nxt = item_key;
          idx_nxt = item_index;
          if (item_op == ucle_pkg::OP_READ) begin
            state_nxt = S_READ;
          end else begin
            // a closed line restarts empty on the next key event
            if (closed_r) begin
              count_nxt  = '0;
              held_nxt   = 16'd0;
              closed_nxt = 1'b0;
            end
            state_nxt = S_CHECK;
          end
        end
      end
      S_READ: begin
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        status_nxt   = ucle_pkg::ST_OPEN;
        rd_valid_nxt = rd_in_range;
        rd_unit_nxt  = rd_in_range ? mem_rdata0 : 16'd0;
        state_nxt    = S_DONE;
      end
      S_CHECK: begin
        rd_valid_nxt = 1'b0;
        rd_unit_nxt  = 16'd0;
        status_nxt   = ucle_pkg::ST_OPEN;
        rep_nxt      = key_r.repeat_req;
        state_nxt    = S_DONE;
        if (!(key_r.is_key && key_r.key_down)) begin
          state_nxt = S_DONE;
        end else if (is_esc) begin
          status_nxt = ucle_pkg::ST_ABORTED;
        end else if (is_ctrl_c || (key_r.repeat_req == 16'd0)) begin
          state_nxt = S_DONE;
        end else if (is_ret) begin
          status_nxt = held_any ? ucle_pkg::ST_INVALID : ucle_pkg::ST_COMPLETE;
        end else begin
          state_nxt = S_EDIT;
        end
      end
      S_EDIT: begin
        if (rep_r == 16'd0) begin
          state_nxt = S_DONE;
        end else if (is_bksp) begin
          if (held_any) begin
            held_nxt = 16'd0;
            rep_nxt  = rep_r - 16'd1;
          end else if (count_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_BK_WAIT;
          end
        end else if (is_print) begin
          if (is_hi) begin
            if (held_any) begin
              status_nxt = ucle_pkg::ST_INVALID;
              state_nxt  = S_DONE;
            end else begin
              held_nxt = key_r.unit;
              rep_nxt  = rep_r - 16'd1;
            end
          end else if (is_lo) begin
            if (!held_any) begin
              status_nxt = ucle_pkg::ST_INVALID;
              state_nxt  = S_DONE;
            end else if (pair_no_room) begin
              status_nxt = ucle_pkg::ST_TOO_LONG;
              state_nxt  = S_DONE;
            end else begin
              // high half first, low half next cycle
              mem_we    = 1'b1;
              mem_wdata = held_r;
              count_nxt = count_r + CW'(1);
              state_nxt = S_PAIR2;
            end
          end else begin
            if (held_any) begin
              status_nxt = ucle_pkg::ST_INVALID;
              state_nxt  = S_DONE;
            end else if (line_full) begin
              status_nxt = ucle_pkg::ST_TOO_LONG;
              state_nxt  = S_DONE;
            end else begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              rep_nxt   = rep_r - 16'd1;
            end
          end
        end else begin
          // other control unit ends the repeats
          state_nxt = S_DONE;
        end
      end
      S_PAIR2: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CW'(1);
        held_nxt  = 16'd0;
        rep_nxt   = rep_r - 16'd1;
        state_nxt = S_EDIT;
      end
      S_BK_WAIT: begin
        // drop a whole pair when the tail is a low half after a high half
        if (ucle_pkg::is_low_half(mem_rdata0) && (count_r != CW'(1)) &&
            ucle_pkg::is_high_half(mem_rdata1)) begin
          count_nxt = count_r - CW'(2);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        rep_nxt   = rep_r - 16'd1;
        state_nxt = S_EDIT;
      end
      S_DONE: begin
        if (res_ready) begin
          if (status_r != ucle_pkg::ST_OPEN) begin
            closed_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      held_r   <= 16'd0;
      closed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      held_r   <= held_nxt;
      closed_r <= closed_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    rep_r      <= rep_nxt;
    status_r   <= status_nxt;
    rd_unit_r  <= rd_unit_nxt;
    rd_valid_r <= rd_valid_nxt;
  end

  // result view
  always_comb begin
    item_ready            = state_r == S_IDLE;
    res_valid             = state_r == S_DONE;
    res.status            = (op_r == ucle_pkg::OP_READ) ? ucle_pkg::ST_OPEN : status_r;
    res.line_length       = 9'(count_r);
    res.surrogate_pending = held_any;
    res.read_unit         = rd_unit_r;
    res.read_valid        = rd_valid_r;
  end

endmodule
